>>> sv/parabolic_trailing_stop_top_defines.svh
// Assertion macros for the parabolic trailing stop block.
// Used by the top level; expects signals named clk and rst in scope.
`ifndef PARABOLIC_TRAILING_STOP_TOP_DEFINES_SVH
`define PARABOLIC_TRAILING_STOP_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/pts_pkg.sv
// Shared types and constants for the parabolic trailing stop block.
// No dependencies; imported by every module of the block.
`default_nettype none

package pts_pkg;

  localparam int unsigned PRICE_BITS_DEF       = 32;
  localparam int unsigned FACTOR_FRAC_BITS_DEF = 16;

  // Fixed port widths of the fields.
  localparam int unsigned PRICE_FIELD_BITS  = 32;
  localparam int unsigned FACTOR_FIELD_BITS = 16;
  localparam int unsigned CFG_DATA_BITS     = 32;
  localparam int unsigned CFG_INDEX_BITS    = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ENABLE       = 3'd0,
    REG_LONG_SIDE    = 3'd1,
    REG_INITIAL_STOP = 3'd2,
    REG_FACTOR_START = 3'd3,
    REG_FACTOR_STEP  = 3'd4,
    REG_FACTOR_MAX   = 3'd5
  } cfg_reg_t;

  // Operating mode handed from the register bank to the datapath.
  typedef struct packed {
    logic enable;
    logic long_side;
  } mode_t;

endpackage

`default_nettype wire

>>> sv/pts_cfg.sv
// Configuration register bank of the parabolic trailing stop block.
// Depends on pts_pkg; raises a one-cycle reload pulse after each valid write.
`default_nettype none

module pts_cfg #(
  parameter int unsigned PRICE_BITS       = pts_pkg::PRICE_BITS_DEF,
  parameter int unsigned FACTOR_FRAC_BITS = pts_pkg::FACTOR_FRAC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [pts_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [pts_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  output pts_pkg::mode_t                             mode,
  output logic      [PRICE_BITS-1:0]                 initial_stop,
  output logic      [FACTOR_FRAC_BITS-1:0]           factor_start,
  output logic      [FACTOR_FRAC_BITS-1:0]           factor_step,
  output logic      [FACTOR_FRAC_BITS-1:0]           factor_max,
  output logic                                       reload
);
  import pts_pkg::*;

  logic [FACTOR_FIELD_BITS-1:0] factor_field;

  assign factor_field = cfg_data[FACTOR_FIELD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode.enable    <= 1'b0;
      mode.long_side <= 1'b1;
      initial_stop   <= '0;
      factor_start   <= '0;
      factor_step    <= '0;
      factor_max     <= '0;
      reload         <= 1'b0;
    end else begin
      reload <= 1'b0;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_ENABLE: begin
            mode.enable <= cfg_data[0];
            reload      <= 1'b1;
          end
          REG_LONG_SIDE: begin
            mode.long_side <= cfg_data[0];
            reload         <= 1'b1;
          end
          REG_INITIAL_STOP: begin
            initial_stop <= PRICE_BITS'(cfg_data);
            reload       <= 1'b1;
          end
          REG_FACTOR_START: begin
            factor_start <= FACTOR_FRAC_BITS'(factor_field);
            reload       <= 1'b1;
          end
          REG_FACTOR_STEP: begin
            factor_step <= FACTOR_FRAC_BITS'(factor_field);
            reload      <= 1'b1;
          end
          REG_FACTOR_MAX: begin
            factor_max <= FACTOR_FRAC_BITS'(factor_field);
            reload     <= 1'b1;
          end
          default: begin
            // Unused indices are ignored and do not reload.
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/pts_update.sv
// Combinational per-bar update of the parabolic trailing stop.
// Depends on pts_pkg; computes the hit flag and the next tracking state.
`default_nettype none

module pts_update #(
  parameter int unsigned PRICE_BITS       = pts_pkg::PRICE_BITS_DEF,
  parameter int unsigned FACTOR_FRAC_BITS = pts_pkg::FACTOR_FRAC_BITS_DEF
) (
  input  wire pts_pkg::mode_t               mode,
  input  wire logic                         first_bar,
  input  wire logic [PRICE_BITS-1:0]        stop_reg,
  input  wire logic [FACTOR_FRAC_BITS-1:0]  factor_reg,
  input  wire logic [PRICE_BITS-1:0]        extreme_high,
  input  wire logic [PRICE_BITS-1:0]        extreme_low,
  input  wire logic [FACTOR_FRAC_BITS-1:0]  factor_step,
  input  wire logic [FACTOR_FRAC_BITS-1:0]  factor_max,
  input  wire logic [PRICE_BITS-1:0]        bar_high,
  input  wire logic [PRICE_BITS-1:0]        bar_low,
  input  wire logic [PRICE_BITS-1:0]        check_price,
  output logic                              hit,
  output logic                              first_bar_next,
  output logic      [PRICE_BITS-1:0]        stop_reg_next,
  output logic      [FACTOR_FRAC_BITS-1:0]  factor_reg_next,
  output logic      [PRICE_BITS-1:0]        extreme_high_next,
  output logic      [PRICE_BITS-1:0]        extreme_low_next
);
  import pts_pkg::*;

  localparam int unsigned PROD_BITS = PRICE_BITS + FACTOR_FRAC_BITS;

  logic                          new_high;
  logic                          new_low;
  logic                          grow;
  logic [PRICE_BITS-1:0]         ext;
  logic [FACTOR_FRAC_BITS:0]     factor_sum;
  logic [FACTOR_FRAC_BITS-1:0]   factor_clip;
  logic [FACTOR_FRAC_BITS-1:0]   factor_upd;
  logic                          ahead;
  logic [PRICE_BITS-1:0]         span;
  logic [PROD_BITS-1:0]          prod;
  logic [PRICE_BITS-1:0]         delta;
  logic [PRICE_BITS-1:0]         stop_moved;

  assign new_high = bar_high > extreme_high;
  assign new_low  = bar_low < extreme_low;
  assign grow     = mode.long_side ? new_high : new_low;

  always_comb begin
    if (mode.long_side) begin
      ext = new_high ? bar_high : extreme_high;
    end else begin
      ext = new_low ? bar_low : extreme_low;
    end
  end

  // The factor saturates at the largest fraction code, just below 1.0.
  assign factor_sum  = {1'b0, factor_reg} + {1'b0, factor_step};
  assign factor_clip = factor_sum[FACTOR_FRAC_BITS] ? '1 : factor_sum[FACTOR_FRAC_BITS-1:0];
  assign factor_upd  = (grow && (factor_reg < factor_max)) ? factor_clip : factor_reg;

  // The truncated step never exceeds the distance, so no wrap can occur.
  assign ahead      = ext >= stop_reg;
  assign span       = ahead ? (ext - stop_reg) : (stop_reg - ext);
  assign prod       = PROD_BITS'(span) * PROD_BITS'(factor_upd);
  assign delta      = prod[PROD_BITS-1:FACTOR_FRAC_BITS];
  assign stop_moved = ahead ? (stop_reg + delta) : (stop_reg - delta);

  always_comb begin
    hit               = 1'b0;
    first_bar_next    = first_bar;
    stop_reg_next     = stop_reg;
    factor_reg_next   = factor_reg;
    extreme_high_next = extreme_high;
    extreme_low_next  = extreme_low;
    if (mode.enable) begin
      hit = mode.long_side ? (check_price < stop_reg) : (check_price > stop_reg);
      if (first_bar) begin
        first_bar_next    = 1'b0;
        extreme_high_next = bar_high;
        extreme_low_next  = bar_low;
      end else begin
        stop_reg_next   = stop_moved;
        factor_reg_next = factor_upd;
        if (mode.long_side) begin
          extreme_high_next = ext;
        end else begin
          extreme_low_next = ext;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/parabolic_trailing_stop_top.sv
// Parabolic trailing stop, top level.
// A bar moves through the input register and then the result register, where out_valid marks it.
// Throughput: one bar per cycle while out_ready is high; the state loop
// (compare, factor add, multiply, add) is combinational between the state registers.
// Reset (synchronous, active high): stop and factor 0, first-bar flag set, extremes 0,
// tracking disabled, long side selected; both pipeline stages empty.
`default_nettype none
`include "parabolic_trailing_stop_top_defines.svh"

module parabolic_trailing_stop_top #(
  parameter int unsigned PRICE_BITS       = pts_pkg::PRICE_BITS_DEF,
  parameter int unsigned FACTOR_FRAC_BITS = pts_pkg::FACTOR_FRAC_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // Configuration write port.
  input  wire logic                                   cfg_write,
  input  wire logic [pts_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire logic [pts_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  // Bar input channel.
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic [pts_pkg::PRICE_FIELD_BITS-1:0]   bar_high,
  input  wire logic [pts_pkg::PRICE_FIELD_BITS-1:0]   bar_low,
  input  wire logic [pts_pkg::PRICE_FIELD_BITS-1:0]   check_price,
  // Result channel.
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic                                        stop_hit,
  output logic      [pts_pkg::PRICE_FIELD_BITS-1:0]   stop_level,
  output logic      [pts_pkg::FACTOR_FIELD_BITS-1:0]  factor_now
);
  import pts_pkg::*;

  // Configuration.
  mode_t                         mode;
  logic [PRICE_BITS-1:0]         initial_stop;
  logic [FACTOR_FRAC_BITS-1:0]   factor_start;
  logic [FACTOR_FRAC_BITS-1:0]   factor_step;
  logic [FACTOR_FRAC_BITS-1:0]   factor_max;
  logic                          reload;

  // Input register stage.
  logic                          s1_valid;
  logic [PRICE_BITS-1:0]         s1_high;
  logic [PRICE_BITS-1:0]         s1_low;
  logic [PRICE_BITS-1:0]         s1_check;
  logic                          s1_adv;
  logic                          s1_fire;

  // Tracking state and its next values.
  logic                          first_bar;
  logic [PRICE_BITS-1:0]         stop_reg;
  logic [FACTOR_FRAC_BITS-1:0]   factor_reg;
  logic [PRICE_BITS-1:0]         extreme_high;
  logic [PRICE_BITS-1:0]         extreme_low;
  logic                          hit;
  logic                          first_bar_next;
  logic [PRICE_BITS-1:0]         stop_reg_next;
  logic [FACTOR_FRAC_BITS-1:0]   factor_reg_next;
  logic [PRICE_BITS-1:0]         extreme_high_next;
  logic [PRICE_BITS-1:0]         extreme_low_next;

  pts_cfg #(
    .PRICE_BITS       (PRICE_BITS),
    .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mode         (mode),
    .initial_stop (initial_stop),
    .factor_start (factor_start),
    .factor_step  (factor_step),
    .factor_max   (factor_max),
    .reload       (reload)
  );

  // The result register is the skid stage: the input register may move on
  // whenever the result register is empty or its transfer completes now.
  assign s1_adv   = !out_valid || out_ready;
  assign s1_fire  = s1_valid && s1_adv;
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // Prices are carried at the internal width, truncated or zero-extended.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_high  <= PRICE_BITS'(bar_high);
      s1_low   <= PRICE_BITS'(bar_low);
      s1_check <= PRICE_BITS'(check_price);
    end
  end

  pts_update #(
    .PRICE_BITS       (PRICE_BITS),
    .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
  ) u_update (
    .mode              (mode),
    .first_bar         (first_bar),
    .stop_reg          (stop_reg),
    .factor_reg        (factor_reg),
    .extreme_high      (extreme_high),
    .extreme_low       (extreme_low),
    .factor_step       (factor_step),
    .factor_max        (factor_max),
    .bar_high          (s1_high),
    .bar_low           (s1_low),
    .check_price       (s1_check),
    .hit               (hit),
    .first_bar_next    (first_bar_next),
    .stop_reg_next     (stop_reg_next),
    .factor_reg_next   (factor_reg_next),
    .extreme_high_next (extreme_high_next),
    .extreme_low_next  (extreme_low_next)
  );

  // The state moves on only when a bar leaves the input register, so each
  // bar sees exactly the state that the bar before it left behind. A
  // configuration write sets its register and the reload pulse, which
  // reloads stop, factor and first-bar flag from them; extremes are kept.
  // The user must write only while idle, so writes and bars never collide; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_bar    <= 1'b1;
      stop_reg     <= '0;
      factor_reg   <= '0;
      extreme_high <= '0;
      extreme_low  <= '0;
    end else if (reload) begin
      first_bar  <= 1'b1;
      stop_reg   <= initial_stop;
      factor_reg <= factor_start;
    end else if (s1_fire) begin
      first_bar    <= first_bar_next;
      stop_reg     <= stop_reg_next;
      factor_reg   <= factor_reg_next;
      extreme_high <= extreme_high_next;
      extreme_low  <= extreme_low_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      stop_hit   <= hit;
      stop_level <= PRICE_FIELD_BITS'(stop_reg_next);
      factor_now <= FACTOR_FIELD_BITS'(factor_reg_next);
    end
  end

  // While tracking is off no bar may trip the stop.
  `PTS_ASSERT_NEXT(a_disabled_no_hit, s1_fire && !mode.enable, out_valid && !stop_hit,
    "stop hit reported while tracking is disabled")

  // While tracking is off and no reload is pending the stop and factor hold.
  `PTS_ASSERT_NEXT(a_disabled_holds, !mode.enable && !reload,
    $stable(stop_reg) && $stable(factor_reg), "stop or factor moved while disabled")

  // A reload always re-arms the first-bar flag.
  `PTS_ASSERT_NEXT(a_reload_first_bar, reload, first_bar,
    "first-bar flag not set after a register write")

  // With both stages full and the result stalled, no new bar is taken.
  `PTS_ASSERT_NOW(a_full_backpressure, s1_valid && out_valid && !out_ready, !in_ready,
    "input accepted while both stages are full and stalled")

endmodule

`default_nettype wire
